### rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned CharW    = 6;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CntW     = 4;   // holds a digit position or count

  localparam logic [CharW-1:0] CharMinus = 6'd45;
  localparam logic [CharW-1:0] CharZero  = 6'd48;

  // Reciprocal of ten: floor(x * RecipTen / 2^35) == x / 10 for every 32-bit x
  localparam logic [ValueW-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShift = 35;

  // Queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } front_state_e;

  // One converted number: sign and digits, least significant first
  typedef struct packed {
    logic                              neg;
    logic [CntW-1:0]                   nd;
    logic [MaxDigits-1:0][DigitW-1:0]  digits;
  } num_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

### rtl/signed_int_to_decimal_ascii_core.sv
// Flow: the front latches the number, extracts its n digits (1..10) one per cycle
// with its reciprocal multiplier and pushes the entry; busy stays high until that
// push. The back emits one beat a cycle while the queue holds an entry.
// Reset: asynchronous, active low; clears control and the queue, no clearing pass.
// The receiver cannot stall: each beat is shown on valid_o for one cycle.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed 32-bit integer into its decimal text, one ASCII character
// per beat, with the last flag on the final character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sitda_pkg::ValueW-1:0] value_i,
  output logic                                valid_o,
  output logic [sitda_pkg::CharW-1:0]         character_o,
  output logic                                last_o
);

  logic                  push;
  logic                  pop;
  sitda_pkg::num_entry_t wr_entry;
  sitda_pkg::num_entry_t head;
  sitda_pkg::q_status_t  q_status;

  sitda_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .value_i    (value_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (wr_entry)
  );

  sitda_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (wr_entry),
    .pop_i    (pop),
    .rdata_o  (head),
    .status_o (q_status)
  );

  sitda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

### rtl/sitda_front.sv
// ----------------------------------------------------------------------------
// sitda_front
// Accepts a number, splits off the sign and extracts the decimal digits,
// one per cycle, by multiplying with a reciprocal of ten.
// ----------------------------------------------------------------------------
module sitda_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [sitda_pkg::ValueW-1:0] value_i,
  input  sitda_pkg::q_status_t              q_status_i,
  output logic                              push_o,
  output sitda_pkg::num_entry_t             entry_o
);

  sitda_pkg::front_state_e state_q, state_d;

  logic                                            neg_q;
  logic [sitda_pkg::ValueW-1:0]                    mag_q;
  logic [sitda_pkg::CntW-1:0]                      cnt_q;
  logic [sitda_pkg::MaxDigits-1:0][sitda_pkg::DigitW-1:0] digits_q;

  logic                                accept;
  logic [2*sitda_pkg::ValueW-1:0]      prod;
  logic [sitda_pkg::ValueW-1:0]        quot;
  logic [sitda_pkg::DigitW+2:0]        quot_x10;
  logic [sitda_pkg::DigitW-1:0]        rem;
  logic                                conv_done;

  assign accept = start_i && (state_q == sitda_pkg::FE_IDLE);

  // Divide by ten: reciprocal multiply, remainder from the low bits only
  assign prod     = mag_q * {{sitda_pkg::ValueW{1'b0}}, sitda_pkg::RecipTen};
  assign quot     = sitda_pkg::ValueW'(prod >> sitda_pkg::RecipShift);
  assign quot_x10 = {quot[3:0], 3'b000} + {2'b00, quot[3:0], 1'b0};
  assign rem      = mag_q[3:0] - quot_x10[3:0];

  assign conv_done = (quot == '0) ||
                     (cnt_q == sitda_pkg::CntW'(sitda_pkg::MaxDigits - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sitda_pkg::FE_IDLE: begin
        if (start_i) state_d = sitda_pkg::FE_CONV;
      end
      sitda_pkg::FE_CONV: begin
        if (conv_done) state_d = sitda_pkg::FE_PUSH;
      end
      sitda_pkg::FE_PUSH: begin
        if (!q_status_i.full) state_d = sitda_pkg::FE_IDLE;
      end
      default: state_d = sitda_pkg::FE_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy_o = 1'b1;
    push_o = 1'b0;
    case (state_q)
      sitda_pkg::FE_IDLE: busy_o = 1'b0;
      sitda_pkg::FE_CONV: busy_o = 1'b1;
      sitda_pkg::FE_PUSH: push_o = !q_status_i.full;
      default:            busy_o = 1'b1;
    endcase
  end

  assign entry_o.neg    = neg_q;
  assign entry_o.nd     = cnt_q;
  assign entry_o.digits = digits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitda_pkg::FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch sign and magnitude, then peel one digit per cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= value_i[sitda_pkg::ValueW-1];
      mag_q <= value_i[sitda_pkg::ValueW-1] ? (32'd0 - value_i) : value_i;
      cnt_q <= '0;
    end else if (state_q == sitda_pkg::FE_CONV) begin
      digits_q[cnt_q] <= rem;
      mag_q           <= quot;
      cnt_q           <= cnt_q + 1'b1;
    end
  end

endmodule

### rtl/sitda_queue.sv
// ----------------------------------------------------------------------------
// sitda_queue
// Two-entry queue of converted numbers between front and back.
// ----------------------------------------------------------------------------
module sitda_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sitda_pkg::num_entry_t wdata_i,
  input  logic                  pop_i,
  output sitda_pkg::num_entry_t rdata_o,
  output sitda_pkg::q_status_t  status_o
);

  sitda_pkg::num_entry_t        mem_q [sitda_pkg::QDepth];
  logic [sitda_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [sitda_pkg::QCntW-1:0]  count_q;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == sitda_pkg::QCntW'(sitda_pkg::QDepth));
  assign rdata_o        = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

### rtl/sitda_back.sv
// ----------------------------------------------------------------------------
// sitda_back
// Emits the queued number as characters: a minus sign first if it is
// negative, then digits from the most significant down, one beat per cycle.
// ----------------------------------------------------------------------------
module sitda_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sitda_pkg::num_entry_t          head_i,
  input  sitda_pkg::q_status_t           q_status_i,
  output logic                           pop_o,
  output logic                           valid_o,
  output logic [sitda_pkg::CharW-1:0]    character_o,
  output logic                           last_o
);

  logic                         sign_done_q;
  logic [sitda_pkg::CntW-1:0]   pos_q;
  logic                         valid_q;
  logic [sitda_pkg::CharW-1:0]  char_q;
  logic                         last_q;

  logic                          emit;
  logic                          sign_beat;
  logic [sitda_pkg::CntW-1:0]    idx;
  logic [sitda_pkg::DigitW-1:0]  digit;
  logic                          digit_last;
  logic [sitda_pkg::CharW-1:0]   char_d;

  assign emit       = !q_status_i.empty;
  assign sign_beat  = head_i.neg && !sign_done_q;
  assign idx        = head_i.nd - 1'b1 - pos_q;
  assign digit_last = (pos_q == head_i.nd - 1'b1);

  // Select digit, out-of-range positions read as zero
  always_comb begin
    digit = '0;
    for (int i = 0; i < sitda_pkg::MaxDigits; i++) begin
      if (idx == sitda_pkg::CntW'(i)) digit = head_i.digits[i];
    end
  end

  assign char_d = sign_beat ? sitda_pkg::CharMinus
                            : sitda_pkg::CharZero + {2'b00, digit};
  assign pop_o  = emit && !sign_beat && digit_last;

  // Track progress through the head entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_done_q <= 1'b0;
      pos_q       <= '0;
      valid_q     <= 1'b0;
    end else begin
      valid_q <= emit;
      if (emit) begin
        if (sign_beat) begin
          sign_done_q <= 1'b1;
        end else if (digit_last) begin
          sign_done_q <= 1'b0;
          pos_q       <= '0;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  // Hold beat payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= char_d;
      last_q <= !sign_beat && digit_last;
    end
  end

  assign valid_o     = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

### sim/tb_signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_core
// Feeds signed 32-bit numbers into the decimal text core and checks every
// character beat and its last flag against a local predictor of the text.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 30;

  typedef struct {
    logic [sitda_pkg::CharW-1:0] ch;
    logic                        last;
  } glyph_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic signed [sitda_pkg::ValueW-1:0] value_i = '0;
  logic                                valid_o;
  logic [sitda_pkg::CharW-1:0]         character_o;
  logic                                last_o;

  logic signed [sitda_pkg::ValueW-1:0] numbers_pending[$];
  glyph_t                              glyphs_due[$];
  logic                                took = 1'b0;
  int                                  gap_left = 0;
  bit                                  burst = 1'b0;
  int                                  errs = 0;
  int unsigned                         cycles = 0;

  signed_int_to_decimal_ascii_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Work out the characters one number should produce, sign first
  task automatic render_decimal(input logic signed [sitda_pkg::ValueW-1:0] v);
    logic [sitda_pkg::ValueW-1:0] mag;
    logic [sitda_pkg::DigitW-1:0] dig [sitda_pkg::MaxDigits];
    int                           nd;
    int                           i;
    glyph_t                       g;
    mag = v[sitda_pkg::ValueW-1] ? (32'd0 - v) : v;
    nd = 0;
    do begin
      dig[nd] = sitda_pkg::DigitW'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0 && nd < sitda_pkg::MaxDigits);
    if (v[sitda_pkg::ValueW-1]) begin
      g.ch = sitda_pkg::CharMinus;
      g.last = 1'b0;
      glyphs_due.push_back(g);
    end
    for (i = nd - 1; i >= 0; i--) begin
      g.ch = sitda_pkg::CharZero + dig[i];
      g.last = (i == 0);
      glyphs_due.push_back(g);
    end
  endtask

  // Random number with a chosen digit count, either sign
  function automatic logic signed [sitda_pkg::ValueW-1:0] pick_by_digits();
    longint lo;
    longint hi;
    longint v;
    int     n;
    int     k;
    n = $urandom_range(1, 10);
    lo = 1;
    for (k = 1; k < n; k++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (n == 1) lo = 0;
    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
    v = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
    if ($urandom_range(0, 1)) v = -v;
    return v[sitda_pkg::ValueW-1:0];
  endfunction

  // Drive the next number at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    logic nxt_start;
    if (rst_ni) begin
      nxt_start = start;
      if (took) begin
        nxt_start = 1'b0;
        if ($urandom_range(0, 15) == 0) burst = ~burst;
        gap_left = burst ? 0 : $urandom_range(0, 10);
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (numbers_pending.size() > 0) begin
          value_i <= numbers_pending.pop_front();
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // Record accepted numbers and check each character beat
  always @(posedge clk_i) begin
    glyph_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni) begin
      took <= start && !busy;
      if (start && !busy) render_decimal(value_i);
      if (valid_o) begin
        if (glyphs_due.size() == 0) begin
          $error("unexpected beat: character %0d last %0b", character_o, last_o);
          errs++;
        end else begin
          want = glyphs_due.pop_front();
          if (character_o !== want.ch) begin
            $error("character: expected %0d, got %0d", want.ch, character_o);
            errs++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            errs++;
          end
        end
      end
    end
  end

  // Fill the stimulus, then wait for the text to drain
  initial begin
    int n;
    int sel;
    numbers_pending = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
      32'sd100, -32'sd100, 32'sd999999999, 32'sd1000000000, -32'sd1000000000,
      32'sd2147483647, -32'sd2147483647, 32'h8000_0000, 32'h8000_0001,
      32'hAAAA_AAAA, 32'h5555_5555, 32'sd1234567890, -32'sd987654321,
      32'sd4294, 32'hFFFF_FFF6, 32'h8000_0000
    };
    for (n = 0; n < 260; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) numbers_pending.push_back($urandom);
      else if (sel < 8) numbers_pending.push_back(pick_by_digits());
      else numbers_pending.push_back($signed($urandom_range(0, 40)) - 20);
    end

    // Hold reset, then release it away from the rising edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (numbers_pending.size() > 0 || start || glyphs_due.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errs == 0 && glyphs_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
